/* rtl/automation_handover_controller_unit_macros.svh */
// Assertion macros shared by the handover controller RTL.
`ifndef AUTOMATION_HANDOVER_CONTROLLER_UNIT_MACROS_SVH
`define AUTOMATION_HANDOVER_CONTROLLER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define AHC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AHC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/ahc_pkg.sv */
// Types, constants and helpers of the automation handover controller.
package ahc_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CMP_W      = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam int SUM_W      = CMP_W + 1;

	localparam int MS_W    = 16;
	localparam int DIST_W  = 14;
	localparam int STEP_W  = 10;
	localparam int IDX_W   = 3;
	localparam int WDATA_W = 16;
	localparam int DEC_W   = 2;

	localparam logic [IDX_W-1:0] REG_DRIVER_REACTION = 3'd0;
	localparam logic [IDX_W-1:0] REG_SYSTEM_REACTION = 3'd1;
	localparam logic [IDX_W-1:0] REG_COOLDOWN        = 3'd2;
	localparam logic [IDX_W-1:0] REG_TAKEOVER_DIST   = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP            = 3'd4;

	localparam logic [DEC_W-1:0] DEC_NONE   = 2'd0;
	localparam logic [DEC_W-1:0] DEC_DRIVER = 2'd1;
	localparam logic [DEC_W-1:0] DEC_SYSTEM = 2'd2;

	localparam logic [MS_W-1:0]   RST_DRIVER_REACTION = 16'd0;
	localparam logic [MS_W-1:0]   RST_SYSTEM_REACTION = 16'd1500;
	localparam logic [MS_W-1:0]   RST_COOLDOWN        = 16'd5000;
	localparam logic [DIST_W-1:0] RST_TAKEOVER_DIST   = 14'd500;
	localparam logic [STEP_W-1:0] RST_STEP            = 10'd100;

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef struct packed {
		logic [MS_W-1:0]   driver_reaction_ms;
		logic [MS_W-1:0]   system_reaction_ms;
		logic [MS_W-1:0]   cooldown_ms;
		logic [DIST_W-1:0] takeover_distance_m;
		logic [STEP_W-1:0] step_ms;
	} cfg_t;

	typedef struct packed {
		logic automated;
		logic want_off;
		logic can_on;
	} status_t;

	function automatic timer_t sat_add(timer_t a, logic [STEP_W-1:0] b);
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] tmax;
		sum  = SUM_W'(a) + SUM_W'(b);
		tmax = SUM_W'({TIMER_BITS{1'b1}});
		return (sum > tmax) ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
	endfunction

endpackage

/* rtl/ahc_sample_if.sv */
// Handshake channel carrying one input word of the handover controller.
interface ahc_sample_if;
	logic                        valid;
	logic                        ready;
	logic                        lane_end_valid;
	logic [ahc_pkg::DIST_W-1:0]  lane_end_distance;
	logic                        ramp_route;
	logic                        on_preferred_lane_rule;
	logic                        gap_search_failed;

	modport source (
		output valid, lane_end_valid, lane_end_distance, ramp_route,
		       on_preferred_lane_rule, gap_search_failed,
		input  ready
	);
	modport sink (
		input  valid, lane_end_valid, lane_end_distance, ramp_route,
		       on_preferred_lane_rule, gap_search_failed,
		output ready
	);
endinterface

/* rtl/ahc_verdict_if.sv */
// Handshake channel carrying one result word of the handover controller.
interface ahc_verdict_if;
	logic                       valid;
	logic                       ready;
	logic [ahc_pkg::DEC_W-1:0]  decision;
	logic                       automated;
	logic                       want_off;
	logic                       can_on;

	modport source (
		output valid, decision, automated, want_off, can_on,
		input  ready
	);
	modport sink (
		input  valid, decision, automated, want_off, can_on,
		output ready
	);
endinterface

/* rtl/ahc_cfg_regs.sv */
// Configuration register bank of the handover controller.
module ahc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ahc_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [ahc_pkg::WDATA_W-1:0]  cfg_wdata,
	output ahc_pkg::cfg_t                cfg
);

	ahc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.driver_reaction_ms  <= ahc_pkg::RST_DRIVER_REACTION;
			cfg_q.system_reaction_ms  <= ahc_pkg::RST_SYSTEM_REACTION;
			cfg_q.cooldown_ms         <= ahc_pkg::RST_COOLDOWN;
			cfg_q.takeover_distance_m <= ahc_pkg::RST_TAKEOVER_DIST;
			cfg_q.step_ms             <= ahc_pkg::RST_STEP;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ahc_pkg::REG_DRIVER_REACTION: begin
					cfg_q.driver_reaction_ms <= cfg_wdata[ahc_pkg::MS_W-1:0];
				end
				ahc_pkg::REG_SYSTEM_REACTION: begin
					cfg_q.system_reaction_ms <= cfg_wdata[ahc_pkg::MS_W-1:0];
				end
				ahc_pkg::REG_COOLDOWN: begin
					cfg_q.cooldown_ms <= cfg_wdata[ahc_pkg::MS_W-1:0];
				end
				ahc_pkg::REG_TAKEOVER_DIST: begin
					cfg_q.takeover_distance_m <= cfg_wdata[ahc_pkg::DIST_W-1:0];
				end
				ahc_pkg::REG_STEP: begin
					cfg_q.step_ms <= cfg_wdata[ahc_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/ahc_decide.sv */
// Takeover decision logic: driver-initiated ahead of system-initiated.
module ahc_decide (
	input  logic                        lane_end_valid,
	input  logic [ahc_pkg::DIST_W-1:0]  lane_end_distance,
	input  logic                        ramp_route,
	input  logic                        on_preferred_lane_rule,
	input  logic                        gap_search_failed,
	input  logic [ahc_pkg::DIST_W-1:0]  takeover_distance_m,
	output logic [ahc_pkg::DEC_W-1:0]   decision
);

	always_comb begin
		priority if (lane_end_valid && ramp_route
				&& (lane_end_distance <= takeover_distance_m)) begin
			decision = ahc_pkg::DEC_DRIVER;
		end else if (on_preferred_lane_rule && gap_search_failed) begin
			decision = ahc_pkg::DEC_SYSTEM;
		end else begin
			decision = ahc_pkg::DEC_NONE;
		end
	end

endmodule

/* rtl/ahc_mode_fsm.sv */
// Mode, reaction timer and cool-down timer state of the handover controller.
`include "automation_handover_controller_unit_macros.svh"

module ahc_mode_fsm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [ahc_pkg::DEC_W-1:0]  decision,
	input  ahc_pkg::cfg_t              cfg,
	output ahc_pkg::status_t           status_nxt
);

	logic                  mode_q, run_q, cd_run_q, want_off_q, can_on_q;
	ahc_pkg::timer_t       el_q, cd_el_q;
	logic [ahc_pkg::MS_W-1:0] lim_q;

	logic                  mode_d, run_d, cd_run_d, want_off_d, can_on_d;
	ahc_pkg::timer_t       el_d, cd_el_d;
	logic [ahc_pkg::MS_W-1:0] lim_d;
	logic                  any_dec;

	assign any_dec = (decision != ahc_pkg::DEC_NONE);

	always_comb begin
		mode_d     = mode_q;
		run_d      = run_q;
		cd_run_d   = cd_run_q;
		want_off_d = want_off_q;
		can_on_d   = can_on_q;
		el_d       = el_q;
		cd_el_d    = cd_el_q;
		lim_d      = lim_q;
		if (mode_q) begin
			if (!run_q) begin
				if (any_dec) begin
					want_off_d = 1'b1;
					can_on_d   = 1'b0;
					run_d      = 1'b1;
					el_d       = '0;
					lim_d      = (decision == ahc_pkg::DEC_DRIVER) ?
						cfg.driver_reaction_ms : cfg.system_reaction_ms;
				end
			end else begin
				el_d = ahc_pkg::sat_add(el_q, cfg.step_ms);
			end
			if (run_d && want_off_d
					&& (ahc_pkg::CMP_W'(el_d) >= ahc_pkg::CMP_W'(lim_d))) begin
				mode_d   = 1'b0;
				run_d    = 1'b0;
				el_d     = '0;
				cd_run_d = 1'b1;
				cd_el_d  = '0;
			end
		end else begin
			if (any_dec) begin
				cd_run_d   = 1'b1;
				cd_el_d    = '0;
				want_off_d = 1'b1;
				can_on_d   = 1'b0;
			end else if (cd_run_q) begin
				cd_el_d    = ahc_pkg::sat_add(cd_el_q, cfg.step_ms);
				want_off_d = 1'b0;
				can_on_d   = 1'b0;
			end
			if (cd_run_d
					&& (ahc_pkg::CMP_W'(cd_el_d) > ahc_pkg::CMP_W'(cfg.cooldown_ms))) begin
				can_on_d = 1'b1;
				cd_run_d = 1'b0;
				cd_el_d  = '0;
			end
			if (can_on_d && !want_off_d) begin
				mode_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b1;
			run_q      <= 1'b0;
			cd_run_q   <= 1'b0;
			want_off_q <= 1'b0;
			can_on_q   <= 1'b0;
			el_q       <= '0;
			cd_el_q    <= '0;
			lim_q      <= '0;
		end else if (advance) begin
			mode_q     <= mode_d;
			run_q      <= run_d;
			cd_run_q   <= cd_run_d;
			want_off_q <= want_off_d;
			can_on_q   <= can_on_d;
			el_q       <= el_d;
			cd_el_q    <= cd_el_d;
			lim_q      <= lim_d;
		end
	end

	assign status_nxt.automated = mode_d;
	assign status_nxt.want_off  = want_off_d;
	assign status_nxt.can_on    = can_on_d;

	`AHC_ASSERT_IMPL(a_run_only_automated, run_q, mode_q, "reaction timer runs in human mode")
	`AHC_ASSERT_IMPL(a_no_cooldown_automated, mode_q, !cd_run_q, "cool-down runs in automated mode")
	`AHC_ASSERT_IMPL(a_run_wants_off, run_q, want_off_q, "reaction timer runs without request")
	`AHC_ASSERT_ALWAYS(a_zero_el_idle, run_q || (el_q == '0), "reaction timer idle but not clear")

endmodule

/* rtl/automation_handover_controller_unit.sv */
// Automation handover controller top level: config bank, decision, mode state, result register.
// One input word is taken per clock cycle while the result register is empty or being drained,
// and its result word appears in the result register in the cycle after it is taken; so the
// sustained rate is one word per cycle while verdict.ready holds. The mode and both timers
// update once per taken word. Configuration writes land on cfg_we.
`include "automation_handover_controller_unit_macros.svh"

module automation_handover_controller_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ahc_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [ahc_pkg::WDATA_W-1:0]  cfg_wdata,
	ahc_sample_if.sink                   sample,
	ahc_verdict_if.source                verdict
);

	ahc_pkg::cfg_t            cfg;
	ahc_pkg::status_t         status_nxt;
	logic [ahc_pkg::DEC_W-1:0] decision;
	logic                     accept;
	logic                     out_valid_q;
	logic [ahc_pkg::DEC_W-1:0] decision_q;
	ahc_pkg::status_t         status_q;

	assign sample.ready = !out_valid_q || verdict.ready;
	assign accept       = sample.valid && sample.ready;

	ahc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ahc_decide u_decide (
		.lane_end_valid         (sample.lane_end_valid),
		.lane_end_distance      (sample.lane_end_distance),
		.ramp_route             (sample.ramp_route),
		.on_preferred_lane_rule (sample.on_preferred_lane_rule),
		.gap_search_failed      (sample.gap_search_failed),
		.takeover_distance_m    (cfg.takeover_distance_m),
		.decision               (decision)
	);

	ahc_mode_fsm u_mode (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept),
		.decision   (decision),
		.cfg        (cfg),
		.status_nxt (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			decision_q <= decision;
			status_q   <= status_nxt;
		end
	end

	assign verdict.valid     = out_valid_q;
	assign verdict.decision  = decision_q;
	assign verdict.automated = status_q.automated;
	assign verdict.want_off  = status_q.want_off;
	assign verdict.can_on    = status_q.can_on;

	`AHC_ASSERT_IMPL(a_stall_blocks_input, out_valid_q && !verdict.ready, !sample.ready, "input taken over a held word")
	`AHC_ASSERT_IMPL(a_accept_fills, accept, ##1 out_valid_q, "accepted word not presented")
	`AHC_ASSERT_IMPL(a_decision_legal, out_valid_q, decision_q != 2'd3, "undefined decision code")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the automation handover controller, with its scoreboard and drivers.
module testbench;
	import ahc_pkg::*;

	typedef struct packed {
		logic              lane_end_valid;
		logic [DIST_W-1:0] lane_end_distance;
		logic              ramp_route;
		logic              on_preferred_lane_rule;
		logic              gap_search_failed;
	} sample_word_t;

	typedef struct packed {
		logic [DEC_W-1:0] decision;
		logic             automated;
		logic             want_off;
		logic             can_on;
	} verdict_word_t;

	typedef enum int {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_t;

	localparam int              SPARE_IDX_LO   = 5;
	localparam int              SPARE_IDX_HI   = 7;
	localparam int              PHASES         = 8;
	localparam int              WORDS_PER_PHASE = 240;
	localparam longint unsigned TIMER_MAX      = (64'd1 << TIMER_BITS) - 1;

	class handover_scoreboard;
		cfg_t            regs;
		logic            automated;
		logic            reaction_running;
		logic            cooldown_running;
		logic            want_off;
		logic            can_on;
		timer_t          reaction_elapsed;
		logic [MS_W-1:0] reaction_limit;
		timer_t          cooldown_elapsed;
		verdict_word_t   pending_verdicts[$];
		int              errors;
		int              checked;
		int              handovers;
		int              resumptions;

		function new();
			regs.driver_reaction_ms  = RST_DRIVER_REACTION;
			regs.system_reaction_ms  = RST_SYSTEM_REACTION;
			regs.cooldown_ms         = RST_COOLDOWN;
			regs.takeover_distance_m = RST_TAKEOVER_DIST;
			regs.step_ms             = RST_STEP;
			automated        = 1'b1;
			reaction_running = 1'b0;
			cooldown_running = 1'b0;
			want_off         = 1'b0;
			can_on           = 1'b0;
			reaction_elapsed = '0;
			reaction_limit   = '0;
			cooldown_elapsed = '0;
			errors      = 0;
			checked     = 0;
			handovers   = 0;
			resumptions = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [WDATA_W-1:0] data);
			case (idx)
			REG_DRIVER_REACTION: regs.driver_reaction_ms  = data[MS_W-1:0];
			REG_SYSTEM_REACTION: regs.system_reaction_ms  = data[MS_W-1:0];
			REG_COOLDOWN:        regs.cooldown_ms         = data[MS_W-1:0];
			REG_TAKEOVER_DIST:   regs.takeover_distance_m = data[DIST_W-1:0];
			REG_STEP:            regs.step_ms             = data[STEP_W-1:0];
			default: ;
			endcase
		endfunction

		function timer_t advance(timer_t t);
			longint unsigned sum;
			sum = longint'(t) + longint'(regs.step_ms);
			return (sum > TIMER_MAX) ? '1 : timer_t'(sum);
		endfunction

		function void note_sample(sample_word_t s);
			verdict_word_t    v;
			logic [DEC_W-1:0] dec;
			logic             was_automated;
			if (s.lane_end_valid && s.ramp_route &&
					s.lane_end_distance <= regs.takeover_distance_m)
				dec = DEC_DRIVER;
			else if (s.on_preferred_lane_rule && s.gap_search_failed)
				dec = DEC_SYSTEM;
			else
				dec = DEC_NONE;
			was_automated = automated;
			if (automated) begin
				if (!reaction_running) begin
					if (dec != DEC_NONE) begin
						want_off         = 1'b1;
						can_on           = 1'b0;
						reaction_running = 1'b1;
						reaction_elapsed = '0;
						reaction_limit   = (dec == DEC_DRIVER) ? regs.driver_reaction_ms
							: regs.system_reaction_ms;
					end
				end else begin
					reaction_elapsed = advance(reaction_elapsed);
				end
				if (reaction_running && want_off && reaction_elapsed >= reaction_limit) begin
					automated        = 1'b0;
					reaction_running = 1'b0;
					reaction_elapsed = '0;
					cooldown_running = 1'b1;
					cooldown_elapsed = '0;
				end
			end else begin
				if (dec != DEC_NONE) begin
					cooldown_running = 1'b1;
					cooldown_elapsed = '0;
					want_off         = 1'b1;
					can_on           = 1'b0;
				end else if (cooldown_running) begin
					cooldown_elapsed = advance(cooldown_elapsed);
					want_off         = 1'b0;
					can_on           = 1'b0;
				end
				if (cooldown_running && cooldown_elapsed > regs.cooldown_ms) begin
					can_on           = 1'b1;
					cooldown_running = 1'b0;
					cooldown_elapsed = '0;
				end
				if (can_on && !want_off)
					automated = 1'b1;
			end
			if (was_automated && !automated)
				handovers++;
			if (!was_automated && automated)
				resumptions++;
			v.decision  = dec;
			v.automated = automated;
			v.want_off  = want_off;
			v.can_on    = can_on;
			pending_verdicts.push_back(v);
		endfunction

		function void compare_field(string what, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_verdict(verdict_word_t got);
			verdict_word_t want;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result word with none expected, expected nothing, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			checked++;
			compare_field("decision", want.decision, got.decision);
			compare_field("automated", want.automated, got.automated);
			compare_field("want_off", want.want_off, got.want_off);
			compare_field("can_on", want.can_on, got.can_on);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_idx;
	logic [WDATA_W-1:0] cfg_wdata;
	flow_t              flow;
	int                 words_in;

	handover_scoreboard board = new();

	ahc_sample_if  sample();
	ahc_verdict_if verdict();

	automation_handover_controller_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sample    (sample),
		.verdict   (verdict)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && sample.valid && sample.ready) begin
			board.note_sample(sample_word_t'{sample.lane_end_valid, sample.lane_end_distance,
				sample.ramp_route, sample.on_preferred_lane_rule, sample.gap_search_failed});
			words_in++;
		end
		if (arst_n && verdict.valid && verdict.ready)
			board.check_verdict(verdict_word_t'{verdict.decision, verdict.automated,
				verdict.want_off, verdict.can_on});
		case (flow)
		FLOW_RECEIVER_STALL: verdict.ready <= ($urandom_range(99) >= 81);
		FLOW_BOTH:           verdict.ready <= ($urandom_range(99) >= 38);
		default:             verdict.ready <= 1'b1;
		endcase
	end

	function automatic sample_word_t word(logic v, logic [DIST_W-1:0] d, logic r, logic p,
			logic g);
		return sample_word_t'{v, d, r, p, g};
	endfunction

	function automatic sample_word_t random_sample(logic [DIST_W-1:0] reach);
		sample_word_t s;
		int unsigned  pick;
		s    = $bits(sample_word_t)'($urandom);
		pick = $urandom_range(199);
		if (pick < 2) begin
			s.lane_end_valid    = 1'b1;
			s.ramp_route        = 1'b1;
			s.lane_end_distance = DIST_W'($urandom_range(int'(reach)));
		end else if (pick < 4) begin
			s.on_preferred_lane_rule = 1'b1;
			s.gap_search_failed      = 1'b1;
		end else if (pick < 8) begin
			s.lane_end_valid    = 1'b1;
			s.ramp_route        = 1'b1;
			s.lane_end_distance = (reach == '1 || pick[0]) ? reach : reach + 1'b1;
		end else begin
			if (s.lane_end_valid && s.ramp_route && s.lane_end_distance <= reach) begin
				if (pick[0])
					s.lane_end_valid = 1'b0;
				else
					s.ramp_route = 1'b0;
			end
			if (s.on_preferred_lane_rule && s.gap_search_failed) begin
				if (pick[1])
					s.on_preferred_lane_rule = 1'b0;
				else
					s.gap_search_failed = 1'b0;
			end
		end
		return s;
	endfunction

	task automatic send_sample(input sample_word_t s);
		int unsigned idle_pct;
		idle_pct = (flow == FLOW_SENDER_IDLE) ? 81 : (flow == FLOW_BOTH) ? 38 : 0;
		while ($urandom_range(99) < idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		{sample.lane_end_valid, sample.lane_end_distance, sample.ramp_route,
			sample.on_preferred_lane_rule, sample.gap_search_failed} <= s;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
	endtask

	// drop valid, then wait for every outstanding result word
	task automatic settle();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WDATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic load_setting(input logic [MS_W-1:0] drv, input logic [MS_W-1:0] sys,
			input logic [MS_W-1:0] cool, input logic [DIST_W-1:0] reach,
			input logic [STEP_W-1:0] stride);
		write_reg(REG_DRIVER_REACTION, drv);
		write_reg(REG_SYSTEM_REACTION, sys);
		write_reg(REG_COOLDOWN, cool);
		write_reg(REG_TAKEOVER_DIST, WDATA_W'(reach));
		write_reg(REG_STEP, WDATA_W'(stride));
		for (int i = SPARE_IDX_LO; i <= SPARE_IDX_HI; i++)
			write_reg(IDX_W'(i), WDATA_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n                        = 1'b0;
		cfg_we                        = 1'b0;
		cfg_idx                       = '0;
		cfg_wdata                     = '0;
		sample.valid                  = 1'b0;
		sample.lane_end_valid         = 1'b0;
		sample.lane_end_distance      = '0;
		sample.ramp_route             = 1'b0;
		sample.on_preferred_lane_rule = 1'b0;
		sample.gap_search_failed      = 1'b0;
		verdict.ready                 = 1'b0;
		flow                          = FLOW_FREE;
		words_in                      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: ramp takeover at the distance limit, zero driver reaction
		send_sample(word(1'b1, 14'd500, 1'b1, 1'b0, 1'b0));
		send_sample(word(1'b0, 14'd0, 1'b0, 1'b0, 1'b0));
		settle();

		load_setting(16'd0, 16'd300, 16'd200, 14'd500, 10'd100);
		send_sample(word(1'b0, 14'd0, 1'b1, 1'b0, 1'b1));
		send_sample(word(1'b1, 14'd16383, 1'b1, 1'b0, 1'b0));
		send_sample(word(1'b0, 14'd16383, 1'b0, 1'b0, 1'b1));
		send_sample(word(1'b0, 14'd0, 1'b0, 1'b1, 1'b1));
		send_sample(word(1'b1, 14'd0, 1'b1, 1'b1, 1'b1));
		send_sample(word(1'b0, 14'd0, 1'b0, 1'b1, 1'b0));
		send_sample(word(1'b0, 14'd0, 1'b0, 1'b0, 1'b0));
		send_sample(word(1'b1, 14'd500, 1'b1, 1'b0, 1'b0));
		repeat (3) send_sample(word(1'b1, 14'd16383, 1'b1, 1'b0, 1'b1));
		send_sample(word(1'b1, 14'd501, 1'b1, 1'b1, 1'b0));
		send_sample(word(1'b1, 14'd0, 1'b1, 1'b0, 1'b0));
		send_sample(word(1'b1, 14'd16383, 1'b0, 1'b1, 1'b1));
		repeat (4) send_sample(word(1'b1, 14'd9000, 1'b1, 1'b0, 1'b1));
		settle();

		for (int p = 0; p < PHASES; p++) begin
			flow <= flow_t'(p % 4);
			case (p)
			0: load_setting(16'd0, 16'd1500, 16'd5000, 14'd500, 10'd100);
			1: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF, 10'd1000);
			2: load_setting(16'd0, 16'd0, 16'd0, 14'd0, 10'd0);
			3: load_setting(16'd100, 16'd200, 16'd30, 14'd8000, 10'd1);
			5: load_setting(MS_W'($urandom), MS_W'($urandom), MS_W'($urandom),
				DIST_W'($urandom), STEP_W'($urandom_range(1000, 1)));
			7: load_setting(16'hFFFF, 16'd0, 16'd1, 14'h3FFF, 10'd1000);
			default: load_setting(MS_W'($urandom_range(2000)), MS_W'($urandom_range(2000)),
				MS_W'($urandom_range(3000)), DIST_W'($urandom),
				STEP_W'($urandom_range(1000, 50)));
			endcase
			repeat (WORDS_PER_PHASE)
				send_sample(random_sample(board.regs.takeover_distance_m));
			settle();
		end

		repeat (4) @(posedge clk);
		$display("Sent %0d input words and checked %0d result words over ten register settings",
			words_in, board.checked);
		$display("and four flow patterns, with %0d handovers and %0d returns to automation.",
			board.handovers, board.resumptions);
		if (board.errors == 0 && board.pending_verdicts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ahc_pkg.sv
rtl/ahc_sample_if.sv
rtl/ahc_verdict_if.sv
rtl/ahc_cfg_regs.sv
rtl/ahc_decide.sv
rtl/ahc_mode_fsm.sv
rtl/automation_handover_controller_unit.sv
tb/testbench.sv
